// ----- rtl/i2cmra_pkg.sv -----
// Package for the I2C master register access block: phase codes, stage codes,
// command codes and register indexes. No dependencies.
package i2cmra_pkg;

    typedef enum logic [20:0] {
        PH_IDLE      = 21'd1 << 0,
        PH_START_A   = 21'd1 << 1,
        PH_START_B   = 21'd1 << 2,
        PH_START_C   = 21'd1 << 3,
        PH_BIT_LOW   = 21'd1 << 4,
        PH_BIT_HIGH  = 21'd1 << 5,
        PH_BIT_HOLD  = 21'd1 << 6,
        PH_ACKW_LOW  = 21'd1 << 7,
        PH_ACKW_HIGH = 21'd1 << 8,
        PH_ACK_DONE  = 21'd1 << 9,
        PH_WAIT_BYTE = 21'd1 << 10,
        PH_RX_LOW    = 21'd1 << 11,
        PH_RX_HIGH   = 21'd1 << 12,
        PH_MACK_LOW  = 21'd1 << 13,
        PH_MACK_HIGH = 21'd1 << 14,
        PH_MACK_HOLD = 21'd1 << 15,
        PH_STOP_A    = 21'd1 << 16,
        PH_STOP_B    = 21'd1 << 17,
        PH_STOP_C    = 21'd1 << 18,
        PH_STOP_D    = 21'd1 << 19,
        PH_RETRY     = 21'd1 << 20
    } phase_t;

    typedef enum logic [1:0] {
        ST_DEV_W = 2'd0,
        ST_REG   = 2'd1,
        ST_DATA  = 2'd2,
        ST_DEV_R = 2'd3
    } stage_t;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_BYTE  = 2'd3;

    localparam logic [1:0] REG_PHASE_TICKS = 2'd0;
    localparam logic [1:0] REG_RETRY_DELAY = 2'd1;
    localparam logic [1:0] REG_MAX_RETRIES = 2'd2;
    localparam logic [1:0] REG_ACK_POLL    = 2'd3;

endpackage

// ----- rtl/i2c_master_register_access_top.sv -----
// I2C master register access, top level: the phase sequencer and result register.
// Depends on i2cmra_pkg.
// Each accepted input transfer is one bus tick; one result transfer follows per tick. The
// sequencer updates in the accept cycle and the result sits in an output register, so a
// transfer is taken every clock while the result side keeps up.
module i2c_master_register_access_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [6:0]  dev_addr,
    input  logic [7:0]  sub_addr,
    input  logic [7:0]  byte_count,
    input  logic [7:0]  wr_byte,
    input  logic        sda_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_out,
    output logic        sda_out,
    output logic [7:0]  rd_byte,
    output logic        rd_valid,
    output logic        need_byte,
    output logic        busy_res,
    output logic        done_res,
    output logic        status
);
    import i2cmra_pkg::*;

    logic [15:0] phase_ticks_reg;
    logic [31:0] retry_delay_reg;
    logic [3:0]  max_retries_reg;
    logic [9:0]  ack_poll_reg;

    phase_t      phase_reg, phase_next;
    stage_t      stage_reg, stage_next;
    logic [15:0] pcount_reg, pcount_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  left_reg, left_next;
    logic [3:0]  retry_reg, retry_next;
    logic [31:0] delay_reg, delay_next;
    logic [9:0]  poll_reg, poll_next;
    logic [6:0]  sdev_reg, sdev_next;
    logic [7:0]  sreg_reg, sreg_next;
    logic [7:0]  scount_reg, scount_next;
    logic        isrd_reg, isrd_next;
    logic        err_reg, err_next;

    logic        ov_reg;
    logic [7:0]  res_rdb_reg;
    logic        res_scl_reg, res_sda_reg, res_rdv_reg, res_need_reg;
    logic        res_busy_reg, res_done_reg, res_st_reg;

    logic        accept;
    logic        over;
    logic [15:0] plen;
    logic [16:0] pinc;
    logic [31:0] dinc;
    logic        bitv, ackv;
    logic        scl, sda, rdv, need, busy, done, st;
    logic [7:0]  rdb;

    assign in_ready = !ov_reg || out_ready;
    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= 16'd1;
            retry_delay_reg <= 32'd55;
            max_retries_reg <= 4'd5;
            ack_poll_reg    <= 10'd250;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PHASE_TICKS: phase_ticks_reg <= cfg_data[15:0];
                REG_RETRY_DELAY: retry_delay_reg <= cfg_data;
                REG_MAX_RETRIES: max_retries_reg <= cfg_data[3:0];
                REG_ACK_POLL:    ack_poll_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign plen = (phase_ticks_reg == 16'd0) ? 16'd1 : phase_ticks_reg;
    assign pinc = {1'b0, pcount_reg} + 17'd1;
    assign over = pinc >= {1'b0, plen};
    assign dinc = delay_reg + 32'd1;
    assign bitv = shift_reg[3'd7 - bit_reg];
    assign ackv = (left_reg == 8'd0);

    always_comb
    begin
        scl = 1'b1;
        sda = 1'b1;
        unique case (phase_reg)
            PH_START_B, PH_STOP_C: sda = 1'b0;
            PH_START_C, PH_STOP_B:
            begin
                scl = 1'b0;
                sda = 1'b0;
            end
            PH_BIT_LOW, PH_BIT_HOLD:
            begin
                scl = 1'b0;
                sda = bitv;
            end
            PH_BIT_HIGH: sda = bitv;
            PH_ACKW_LOW, PH_ACK_DONE, PH_WAIT_BYTE, PH_RX_LOW, PH_STOP_A: scl = 1'b0;
            PH_MACK_LOW, PH_MACK_HOLD:
            begin
                scl = 1'b0;
                sda = ackv;
            end
            PH_MACK_HIGH: sda = ackv;
            default: ;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        stage_next  = stage_reg;
        pcount_next = over ? 16'd0 : pinc[15:0];
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        left_next   = left_reg;
        retry_next  = retry_reg;
        delay_next  = delay_reg;
        poll_next   = poll_reg;
        sdev_next   = sdev_reg;
        sreg_next   = sreg_reg;
        scount_next = scount_reg;
        isrd_next   = isrd_reg;
        err_next    = err_reg;
        rdv  = 1'b0;
        rdb  = 8'd0;
        done = 1'b0;
        st   = 1'b0;
        need = (phase_reg == PH_WAIT_BYTE);
        busy = (phase_reg != PH_IDLE);

        unique case (phase_reg)
            PH_IDLE:
            begin
                pcount_next = pcount_reg;
                if (cmd == CMD_WRITE || cmd == CMD_READ)
                begin
                    sdev_next   = dev_addr;
                    sreg_next   = sub_addr;
                    scount_next = byte_count;
                    isrd_next   = (cmd == CMD_READ);
                    retry_next  = 4'd0;
                    delay_next  = 32'd0;
                    busy        = 1'b1;
                    stage_next  = ST_DEV_W;
                    left_next   = byte_count;
                    err_next    = 1'b0;
                    bit_next    = 3'd0;
                    shift_next  = 8'd0;
                    poll_next   = 10'd0;
                    phase_next  = PH_START_A;
                    pcount_next = 16'd0;
                end
            end
            PH_START_A: if (over) phase_next = PH_START_B;
            PH_START_B: if (over) phase_next = PH_START_C;
            PH_START_C:
                if (over)
                begin
                    shift_next = {sdev_reg, stage_reg == ST_DEV_R};
                    bit_next   = 3'd0;
                    phase_next = PH_BIT_LOW;
                end
            PH_BIT_LOW:  if (over) phase_next = PH_BIT_HIGH;
            PH_BIT_HIGH: if (over) phase_next = PH_BIT_HOLD;
            PH_BIT_HOLD:
                if (over)
                begin
                    if (bit_reg == 3'd7)
                        phase_next = PH_ACKW_LOW;
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_BIT_LOW;
                    end
                end
            PH_ACKW_LOW:
                if (over)
                begin
                    poll_next  = 10'd0;
                    phase_next = PH_ACKW_HIGH;
                end
            PH_ACKW_HIGH:
            begin
                pcount_next = pcount_reg;
                if (!sda_in)
                begin
                    phase_next  = PH_ACK_DONE;
                    pcount_next = 16'd0;
                end
                else if (poll_reg >= ack_poll_reg)
                begin
                    err_next    = 1'b1;
                    phase_next  = PH_STOP_A;
                    pcount_next = 16'd0;
                end
                else
                    poll_next = poll_reg + 10'd1;
            end
            PH_ACK_DONE:
                if (over)
                begin
                    case (stage_reg)
                        ST_DEV_W:
                        begin
                            stage_next = ST_REG;
                            shift_next = sreg_reg;
                            bit_next   = 3'd0;
                            phase_next = PH_BIT_LOW;
                        end
                        ST_REG:
                            if (isrd_reg)
                            begin
                                stage_next = ST_DEV_R;
                                phase_next = PH_START_A;
                            end
                            else
                            begin
                                stage_next = ST_DATA;
                                phase_next = (left_reg == 8'd0) ? PH_STOP_A : PH_WAIT_BYTE;
                            end
                        ST_DATA:
                        begin
                            if (left_reg != 8'd0)
                                left_next = left_reg - 8'd1;
                            phase_next = (left_reg <= 8'd1) ? PH_STOP_A : PH_WAIT_BYTE;
                        end
                        default:
                            if (left_reg == 8'd0)
                                phase_next = PH_STOP_A;
                            else
                            begin
                                bit_next   = 3'd0;
                                shift_next = 8'd0;
                                phase_next = PH_RX_LOW;
                            end
                    endcase
                end
            PH_WAIT_BYTE:
            begin
                pcount_next = pcount_reg;
                if (cmd == CMD_BYTE)
                begin
                    shift_next  = wr_byte;
                    bit_next    = 3'd0;
                    phase_next  = PH_BIT_LOW;
                    pcount_next = 16'd0;
                end
            end
            PH_RX_LOW: if (over) phase_next = PH_RX_HIGH;
            PH_RX_HIGH:
                if (over)
                begin
                    shift_next = {shift_reg[6:0], sda_in};
                    if (bit_reg == 3'd7)
                    begin
                        rdv = 1'b1;
                        rdb = {shift_reg[6:0], sda_in};
                        if (left_reg != 8'd0)
                            left_next = left_reg - 8'd1;
                        phase_next = PH_MACK_LOW;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_RX_LOW;
                    end
                end
            PH_MACK_LOW:  if (over) phase_next = PH_MACK_HIGH;
            PH_MACK_HIGH: if (over) phase_next = PH_MACK_HOLD;
            PH_MACK_HOLD:
                if (over)
                begin
                    if (left_reg == 8'd0)
                        phase_next = PH_STOP_A;
                    else
                    begin
                        bit_next   = 3'd0;
                        shift_next = 8'd0;
                        phase_next = PH_RX_LOW;
                    end
                end
            PH_STOP_A: if (over) phase_next = PH_STOP_B;
            PH_STOP_B: if (over) phase_next = PH_STOP_C;
            PH_STOP_C: if (over) phase_next = PH_STOP_D;
            PH_STOP_D:
                if (over)
                begin
                    if (err_reg && retry_delay_reg != 32'd0 && retry_reg < max_retries_reg)
                    begin
                        retry_next = retry_reg + 4'd1;
                        delay_next = 32'd0;
                        phase_next = PH_RETRY;
                    end
                    else
                    begin
                        done       = 1'b1;
                        st         = err_reg;
                        err_next   = 1'b0;
                        phase_next = PH_IDLE;
                    end
                end
            PH_RETRY:
            begin
                pcount_next = pcount_reg;
                delay_next  = dinc;
                if (dinc >= retry_delay_reg)
                begin
                    stage_next  = ST_DEV_W;
                    left_next   = scount_reg;
                    err_next    = 1'b0;
                    bit_next    = 3'd0;
                    shift_next  = 8'd0;
                    poll_next   = 10'd0;
                    phase_next  = PH_START_A;
                    pcount_next = 16'd0;
                end
            end
            default:
            begin
                phase_next  = PH_IDLE;
                pcount_next = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            stage_reg  <= ST_DEV_W;
            pcount_reg <= 16'd0;
            bit_reg    <= 3'd0;
            shift_reg  <= 8'd0;
            left_reg   <= 8'd0;
            retry_reg  <= 4'd0;
            delay_reg  <= 32'd0;
            poll_reg   <= 10'd0;
            sdev_reg   <= 7'd0;
            sreg_reg   <= 8'd0;
            scount_reg <= 8'd0;
            isrd_reg   <= 1'b0;
            err_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            stage_reg  <= stage_next;
            pcount_reg <= pcount_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            left_reg   <= left_next;
            retry_reg  <= retry_next;
            delay_reg  <= delay_next;
            poll_reg   <= poll_next;
            sdev_reg   <= sdev_next;
            sreg_reg   <= sreg_next;
            scount_reg <= scount_next;
            isrd_reg   <= isrd_next;
            err_reg    <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (accept)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_scl_reg  <= scl;
            res_sda_reg  <= sda;
            res_rdb_reg  <= rdb;
            res_rdv_reg  <= rdv;
            res_need_reg <= need;
            res_busy_reg <= busy;
            res_done_reg <= done;
            res_st_reg   <= st;
        end
    end

    assign out_valid = ov_reg;
    assign scl_out   = res_scl_reg;
    assign sda_out   = res_sda_reg;
    assign rd_byte   = res_rdb_reg;
    assign rd_valid  = res_rdv_reg;
    assign need_byte = res_need_reg;
    assign busy_res  = res_busy_reg;
    assign done_res  = res_done_reg;
    assign status    = res_st_reg;

    // The phase register always holds exactly one phase.
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    // A completed transaction always returns the sequencer to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && done |=> phase_reg == PH_IDLE)
        else $error("done without return to idle");

    // A retry wait is only ever entered after a retry has been counted.
    a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RETRY |-> retry_reg != 4'd0)
        else $error("retry wait without a counted retry");

endmodule

// ----- sim/tb.sv -----
// Testbench for i2c_master_register_access_top: drives bus ticks with a responding
// target, predicts every result transfer and compares it field by field.
// Depends on i2cmra_pkg and the top level in rtl.
module tb;
    import i2cmra_pkg::*;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] rdb;
        logic       rdv;
        logic       need;
        logic       busy;
        logic       done;
        logic       st;
    } bus_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = CMD_TICK;
    logic [6:0]  dev_addr = '0;
    logic [7:0]  sub_addr = '0;
    logic [7:0]  byte_count = '0;
    logic [7:0]  wr_byte = '0;
    logic        sda_in = 1'b1;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        scl_out, sda_out, rd_valid, need_byte, busy_res, done_res, status;
    logic [7:0]  rd_byte;

    i2c_master_register_access_top dut (.*);

    always #5 clk = ~clk;

    // Predictor state and configuration.
    phase_t      ph;
    stage_t      stg;
    logic [15:0] pcnt, c_phase;
    logic [2:0]  bidx;
    logic [7:0]  shf, left, sreg, scnt;
    logic [3:0]  rcnt, c_maxr;
    logic [31:0] dcnt, c_delay;
    logic [9:0]  poll, c_poll;
    logic [6:0]  sdev;
    logic        rd_txn, err;

    bus_res_t    bus_expected[$];
    int          n_sent = 0, n_checked = 0, n_bad = 0, n_done = 0, n_fail_done = 0;
    int          n_rd = 0, idle_cnt = 0;
    int          in_idle = 0, out_idle = 0, nack_pct = 0, big_pct = 0;
    bit          nack_txn = 0;

    function void go_phase(phase_t p);
        ph = p;
        pcnt = '0;
    endfunction

    function bit phase_end();
        logic [16:0] c;
        logic [16:0] len;
        len = (c_phase == 0) ? 17'd1 : {1'b0, c_phase};
        c = pcnt + 17'd1;
        if (c >= len) begin
            pcnt = '0;
            return 1'b1;
        end
        pcnt = c[15:0];
        return 1'b0;
    endfunction

    function void load_byte(logic [7:0] v);
        shf = v;
        bidx = '0;
        go_phase(PH_BIT_LOW);
    endfunction

    function void new_attempt();
        stg = ST_DEV_W;
        left = scnt;
        err = 1'b0;
        bidx = '0;
        shf = '0;
        poll = '0;
        go_phase(PH_START_A);
    endfunction

    function void rx_begin();
        bidx = '0;
        shf = '0;
        go_phase(PH_RX_LOW);
    endfunction

    function void acked();
        case (stg)
            ST_DEV_W:
            begin
                stg = ST_REG;
                load_byte(sreg);
            end
            ST_REG:
            begin
                if (rd_txn)
                begin
                    stg = ST_DEV_R;
                    go_phase(PH_START_A);
                end
                else
                begin
                    stg = ST_DATA;
                    go_phase(left == 0 ? PH_STOP_A : PH_WAIT_BYTE);
                end
            end
            ST_DATA:
            begin
                if (left != 0)
                    left = left - 8'd1;
                go_phase(left == 0 ? PH_STOP_A : PH_WAIT_BYTE);
            end
            default:
            begin
                if (left == 0)
                    go_phase(PH_STOP_A);
                else
                    rx_begin();
            end
        endcase
    endfunction

    function void model_reset();
        c_phase = 16'd1;
        c_delay = 32'd55;
        c_maxr = 4'd5;
        c_poll = 10'd250;
        ph = PH_IDLE;
        stg = ST_DEV_W;
        pcnt = '0; bidx = '0; shf = '0; left = '0; rcnt = '0; dcnt = '0; poll = '0;
        sdev = '0; sreg = '0; scnt = '0; rd_txn = 1'b0; err = 1'b0;
    endfunction

    function bus_res_t bus_tick(logic [1:0] c, logic [6:0] da, logic [7:0] ra,
                                logic [7:0] bc, logic [7:0] wb, logic sd);
        bus_res_t r;
        logic     bitv, ackv;
        bitv = shf[3'd7 - bidx];
        ackv = (left == 0);
        r = '0;
        r.scl = 1'b1;
        r.sda = 1'b1;
        r.need = (ph == PH_WAIT_BYTE);
        r.busy = (ph != PH_IDLE);
        case (ph)
            PH_START_B: r.sda = 1'b0;
            PH_START_C, PH_STOP_B: begin r.scl = 1'b0; r.sda = 1'b0; end
            PH_BIT_LOW, PH_BIT_HOLD: begin r.scl = 1'b0; r.sda = bitv; end
            PH_BIT_HIGH: r.sda = bitv;
            PH_ACKW_LOW, PH_ACK_DONE, PH_WAIT_BYTE, PH_RX_LOW, PH_STOP_A: r.scl = 1'b0;
            PH_MACK_LOW, PH_MACK_HOLD: begin r.scl = 1'b0; r.sda = ackv; end
            PH_MACK_HIGH: r.sda = ackv;
            PH_STOP_C: r.sda = 1'b0;
            default: ;
        endcase
        case (ph)
            PH_IDLE:
            begin
                if (c == CMD_WRITE || c == CMD_READ)
                begin
                    sdev = da;
                    sreg = ra;
                    scnt = bc;
                    rd_txn = (c == CMD_READ);
                    rcnt = '0;
                    dcnt = '0;
                    r.busy = 1'b1;
                    new_attempt();
                end
            end
            PH_START_A: if (phase_end()) go_phase(PH_START_B);
            PH_START_B: if (phase_end()) go_phase(PH_START_C);
            PH_START_C: if (phase_end()) load_byte({sdev, stg == ST_DEV_R});
            PH_BIT_LOW: if (phase_end()) go_phase(PH_BIT_HIGH);
            PH_BIT_HIGH: if (phase_end()) go_phase(PH_BIT_HOLD);
            PH_BIT_HOLD:
            begin
                if (phase_end())
                begin
                    if (bidx == 3'd7)
                        go_phase(PH_ACKW_LOW);
                    else
                    begin
                        bidx = bidx + 3'd1;
                        go_phase(PH_BIT_LOW);
                    end
                end
            end
            PH_ACKW_LOW:
            begin
                if (phase_end())
                begin
                    poll = '0;
                    go_phase(PH_ACKW_HIGH);
                end
            end
            PH_ACKW_HIGH:
            begin
                if (!sd)
                    go_phase(PH_ACK_DONE);
                else if (poll >= c_poll)
                begin
                    err = 1'b1;
                    go_phase(PH_STOP_A);
                end
                else
                    poll = poll + 10'd1;
            end
            PH_ACK_DONE: if (phase_end()) acked();
            PH_WAIT_BYTE: if (c == CMD_BYTE) load_byte(wb);
            PH_RX_LOW: if (phase_end()) go_phase(PH_RX_HIGH);
            PH_RX_HIGH:
            begin
                if (phase_end())
                begin
                    shf = {shf[6:0], sd};
                    if (bidx == 3'd7)
                    begin
                        r.rdv = 1'b1;
                        r.rdb = shf;
                        if (left != 0)
                            left = left - 8'd1;
                        go_phase(PH_MACK_LOW);
                    end
                    else
                    begin
                        bidx = bidx + 3'd1;
                        go_phase(PH_RX_LOW);
                    end
                end
            end
            PH_MACK_LOW: if (phase_end()) go_phase(PH_MACK_HIGH);
            PH_MACK_HIGH: if (phase_end()) go_phase(PH_MACK_HOLD);
            PH_MACK_HOLD:
            begin
                if (phase_end())
                begin
                    if (left == 0)
                        go_phase(PH_STOP_A);
                    else
                        rx_begin();
                end
            end
            PH_STOP_A: if (phase_end()) go_phase(PH_STOP_B);
            PH_STOP_B: if (phase_end()) go_phase(PH_STOP_C);
            PH_STOP_C: if (phase_end()) go_phase(PH_STOP_D);
            PH_STOP_D:
            begin
                if (phase_end())
                begin
                    if (err && c_delay != 0 && rcnt < c_maxr)
                    begin
                        rcnt = rcnt + 4'd1;
                        dcnt = '0;
                        go_phase(PH_RETRY);
                    end
                    else
                    begin
                        r.done = 1'b1;
                        r.st = err;
                        err = 1'b0;
                        go_phase(PH_IDLE);
                    end
                end
            end
            PH_RETRY:
            begin
                dcnt = dcnt + 32'd1;
                if (dcnt >= c_delay)
                    new_attempt();
            end
            default: go_phase(PH_IDLE);
        endcase
        return r;
    endfunction

    // Sends one tick and records its predicted result once the transfer is taken.
    task automatic send_tick(logic [1:0] c, logic [6:0] da, logic [7:0] ra,
                             logic [7:0] bc, logic [7:0] wb, logic sd);
        int gap;
        bus_res_t r;
        gap = ($urandom_range(99) < in_idle) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd <= c;
        dev_addr <= da;
        sub_addr <= ra;
        byte_count <= bc;
        wr_byte <= wb;
        sda_in <= sd;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        r = bus_tick(c, da, ra, bc, wb, sd);
        bus_expected.push_back(r);
        n_sent++;
    endtask

    // Chooses the next tick from the predicted phase, acting as a responding target.
    task automatic drive_tick(bit allow_start, logic [7:0] cnt_hint, bit use_hint,
                              logic [1:0] start_cmd);
        logic [1:0] c;
        logic [7:0] bc;
        logic       sd;
        c = ($urandom_range(99) < 90) ? CMD_TICK : 2'($urandom_range(3));
        bc = 8'($urandom_range(255));
        sd = 1'($urandom_range(1));
        if (ph == PH_IDLE)
        begin
            if (allow_start)
            begin
                c = start_cmd;
                if (use_hint)
                    bc = cnt_hint;
                else if ($urandom_range(99) >= big_pct)
                    bc = 8'($urandom_range(3));
                nack_txn = ($urandom_range(99) < nack_pct);
            end
            else
                c = ($urandom_range(1) == 1) ? CMD_BYTE : CMD_TICK;
        end
        else if (ph == PH_WAIT_BYTE)
            c = ($urandom_range(99) < 85) ? CMD_BYTE : 2'($urandom_range(2));
        else if (ph == PH_ACKW_HIGH)
            sd = nack_txn ? 1'b1 : ($urandom_range(3) == 0);
        send_tick(c, 7'($urandom_range(127)), 8'($urandom_range(255)), bc,
                  8'($urandom_range(255)), sd);
    endtask

    task automatic run_txn(logic [1:0] start_cmd, logic [7:0] cnt, bit nack);
        drive_tick(1'b1, cnt, 1'b1, start_cmd);
        nack_txn = nack;
        while (ph != PH_IDLE)
            drive_tick(1'b0, 8'd0, 1'b0, CMD_TICK);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (bus_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        while (ph != PH_IDLE)
            drive_tick(1'b0, 8'd0, 1'b0, CMD_TICK);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PHASE_TICKS: c_phase = val[15:0];
            REG_RETRY_DELAY: c_delay = val;
            REG_MAX_RETRIES: c_maxr = val[3:0];
            default:         c_poll = val[9:0];
        endcase
    endtask

    task automatic test_basic_transfers();
        run_txn(CMD_WRITE, 8'd2, 1'b0);
        run_txn(CMD_READ, 8'd3, 1'b0);
        run_txn(CMD_WRITE, 8'd0, 1'b0);
        run_txn(CMD_READ, 8'd0, 1'b0);
        send_tick(CMD_WRITE, 7'h7f, 8'hff, 8'd1, 8'hff, 1'b0);
        send_tick(CMD_READ, 7'h00, 8'h00, 8'd0, 8'h00, 1'b1);
        send_tick(CMD_BYTE, 7'h55, 8'haa, 8'd0, 8'h5a, 1'b0);
        while (ph != PH_IDLE)
            drive_tick(1'b0, 8'd0, 1'b0, CMD_TICK);
        send_tick(CMD_READ, 7'h00, 8'h00, 8'd1, 8'h00, 1'b0);
        while (ph != PH_IDLE)
            drive_tick(1'b0, 8'd0, 1'b0, CMD_TICK);
    endtask

    task automatic test_timeouts();
        write_reg(REG_ACK_POLL, 32'd0);
        write_reg(REG_RETRY_DELAY, 32'd3);
        write_reg(REG_MAX_RETRIES, 32'd2);
        run_txn(CMD_WRITE, 8'd1, 1'b1);
        write_reg(REG_MAX_RETRIES, 32'd15);
        write_reg(REG_RETRY_DELAY, 32'd1);
        run_txn(CMD_READ, 8'd1, 1'b1);
        write_reg(REG_RETRY_DELAY, 32'd0);
        run_txn(CMD_WRITE, 8'd1, 1'b1);
        write_reg(REG_ACK_POLL, 32'd1023);
        write_reg(REG_MAX_RETRIES, 32'd0);
        write_reg(REG_RETRY_DELAY, 32'd4);
        run_txn(CMD_WRITE, 8'd1, 1'b1);
        write_reg(REG_ACK_POLL, 32'd2);
        run_txn(CMD_READ, 8'd2, 1'b0);
    endtask

    task automatic test_timing_extremes();
        write_reg(REG_PHASE_TICKS, 32'd0);
        run_txn(CMD_READ, 8'd1, 1'b0);
        write_reg(REG_PHASE_TICKS, 32'd65535);
        repeat (20)
            drive_tick(1'b0, 8'd0, 1'b0, CMD_TICK);
        write_reg(REG_PHASE_TICKS, 32'd3);
        write_reg(REG_ACK_POLL, 32'd1023);
        write_reg(REG_RETRY_DELAY, 32'hffff_ffff);
        write_reg(REG_MAX_RETRIES, 32'd1);
        run_txn(CMD_WRITE, 8'd2, 1'b0);
        write_reg(REG_PHASE_TICKS, 32'd1);
        run_txn(CMD_READ, 8'd4, 1'b0);
    endtask

    task automatic test_random_traffic();
        int target;
        int mode;
        for (mode = 0; mode < 3; mode++)
        begin
            in_idle = (mode == 0) ? 37 : (mode == 1) ? 75 : 0;
            out_idle = (mode == 0) ? 75 : (mode == 1) ? 37 : 0;
            write_reg(REG_PHASE_TICKS, 32'($urandom_range(1, 2)));
            write_reg(REG_RETRY_DELAY, 32'($urandom_range(0, 6)));
            write_reg(REG_MAX_RETRIES, 32'($urandom_range(0, 3)));
            write_reg(REG_ACK_POLL, 32'($urandom_range(0, 4)));
            nack_pct = 12;
            big_pct = 0;
            target = n_sent + 200;
            while (n_sent < target)
            begin
                drive_tick($urandom_range(9) != 0, 8'd0, 1'b0,
                           ($urandom_range(1) == 1) ? CMD_READ : CMD_WRITE);
                if ($urandom_range(299) == 0)
                begin
                    in_valid <= 1'b0;
                    while (bus_expected.size() != 0)
                        @(posedge clk);
                end
            end
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_idle);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 20000)
        begin
            $display("i2c_master_register_access_top: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        bus_res_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {scl_out, sda_out, rd_byte, rd_valid, need_byte, busy_res, done_res, status};
            if (bus_expected.size() == 0)
            begin
                n_bad++;
                if (n_bad <= 10)
                    $display("Unexpected result transfer %h at %0t.", got, $time);
            end
            else
            begin
                want = bus_expected.pop_front();
                n_checked++;
                if (want.done) n_done++;
                if (want.done && want.st) n_fail_done++;
                if (want.rdv) n_rd++;
                if (got !== want)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("Result %0d differs: scl %b/%b sda %b/%b rd_byte %h/%h %s %b/%b",
                                 n_checked, want.scl, got.scl, want.sda, got.sda, want.rdb,
                                 got.rdb, "rd_valid need busy done status",
                                 {want.rdv, want.need, want.busy, want.done, want.st},
                                 {got.rdv, got.need, got.busy, got.done, got.st});
                end
            end
        end
    end

    initial
    begin
        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_transfers();
        test_timeouts();
        test_timing_extremes();
        test_random_traffic();
        drain();
        n_bad += bus_expected.size();
        $display("Sent %0d ticks and checked %0d results over several register settings.",
                 n_sent, n_checked);
        $display("Finished %0d transactions, %0d with a timeout, and read %0d bytes.",
                 n_done, n_fail_done, n_rd);
        if (n_bad == 0)
            $display("i2c_master_register_access_top: match");
        else
            $display("i2c_master_register_access_top: mismatch");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/i2cmra_pkg.sv
rtl/i2c_master_register_access_top.sv
sim/tb.sv
